### rtl/ssfm_pkg.sv
// Shared types, constants and helper functions for the stream slowdown monitor.
// No dependencies; every other file of the block but ssfm_checker uses this package.
`default_nettype none

package ssfm_pkg;

   localparam int SUM_W      = 48;
   localparam int CNT_W      = 32;
   localparam int ALONE_W    = 32;
   localparam int TIME_W     = 48;
   localparam int STREAM_W   = 2;
   localparam int CHAN_W     = 3;
   localparam int CHIP_W     = 2;
   localparam int KIND_W     = 2;
   localparam int SLOW_W     = 64;
   localparam int FRAC_W     = 16;
   localparam int DVD_W      = SLOW_W + FRAC_W;
   localparam int FAIR_W     = 17;
   localparam int PROP_W     = 32;
   localparam int ENTRY_W    = 2 * SUM_W;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 184;

   localparam int DEF_NUM_STREAMS       = 4;
   localparam int DEF_NUM_CHANNELS      = 8;
   localparam int DEF_CHIPS_PER_CHANNEL = 4;

   localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic              SCOPE_CHIP = 1'b1;
   localparam logic              REQ_QUERY  = 1'b1;

   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [FAIR_W-1:0] FAIR_ONE = 17'h10000;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_REC_RD,
      ST_REC_WR,
      ST_Q_RD,
      ST_Q_CHK,
      ST_Q_DIV,
      ST_FAIR,
      ST_FAIR_WAIT,
      ST_PROP,
      ST_PROP_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_SLOW,
      DIV_FAIR,
      DIV_PROP
   } div_sel_type;

   typedef struct packed {
      logic        clear_wr;
      logic        latch;
      logic        mem_rd;
      logic        walk_mode;
      logic        rec_wr;
      logic        walk_upd;
      logic        walk_next;
      logic        div_start;
      div_sel_type div_sel;
      logic        fair_ld;
      logic        prop_ld;
      logic        out_ld;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_query;
      logic alone_zero;
      logic walk_last;
      logic div_done;
      logic fair_direct;
      logic prop_direct;
      logic out_free;
   } status_type;

   function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] a);
      return (a == CNT_MAX) ? a : a + 1'b1;
   endfunction

endpackage

`default_nettype wire

### rtl/ssfm_div.sv
// Restoring divider, one quotient bit per cycle, for slowdowns and ratios.
// Depends on ssfm_pkg.
`default_nettype none

module ssfm_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ssfm_pkg::DVD_W-1:0]  dividend,
   input  wire logic [ssfm_pkg::SLOW_W-1:0] divisor,
   output logic                             done,
   output logic [ssfm_pkg::DVD_W-1:0]       quotient
);

   localparam int DW = ssfm_pkg::DVD_W;
   localparam int RW = ssfm_pkg::SLOW_W;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dvd_ff, dvd_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] den_ff, den_in;
   logic [RW:0]   rem_sh;
   logic [RW:0]   diff;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DW-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      diff    = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
         dvd_in = {dvd_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

### rtl/ssfm_ctrl.sv
// Sequencer for clearing sweep, record, query walk, ratio divisions and result hand-off.
// Depends on ssfm_pkg; drives the datapath through cmd_type and reads status_type.
`default_nettype none

module ssfm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire ssfm_pkg::status_type   status,
   output ssfm_pkg::cmd_type           cmd
);

   ssfm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssfm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssfm_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = ssfm_pkg::ST_IDLE;
         end
         ssfm_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ssfm_pkg::ST_DECODE;
         end
         ssfm_pkg::ST_DECODE: begin
            state_in = status.is_query ? ssfm_pkg::ST_Q_RD : ssfm_pkg::ST_REC_RD;
         end
         ssfm_pkg::ST_REC_RD: state_in = ssfm_pkg::ST_REC_WR;
         ssfm_pkg::ST_REC_WR: state_in = ssfm_pkg::ST_DONE;
         ssfm_pkg::ST_Q_RD:   state_in = ssfm_pkg::ST_Q_CHK;
         ssfm_pkg::ST_Q_CHK: begin
            if (!status.alone_zero) state_in = ssfm_pkg::ST_Q_DIV;
            else if (status.walk_last) state_in = ssfm_pkg::ST_FAIR;
            else state_in = ssfm_pkg::ST_Q_RD;
         end
         ssfm_pkg::ST_Q_DIV: begin
            if (status.div_done) begin
               state_in = status.walk_last ? ssfm_pkg::ST_FAIR : ssfm_pkg::ST_Q_RD;
            end
         end
         ssfm_pkg::ST_FAIR: begin
            state_in = status.fair_direct ? ssfm_pkg::ST_PROP : ssfm_pkg::ST_FAIR_WAIT;
         end
         ssfm_pkg::ST_FAIR_WAIT: begin
            if (status.div_done) state_in = ssfm_pkg::ST_PROP;
         end
         ssfm_pkg::ST_PROP: begin
            state_in = status.prop_direct ? ssfm_pkg::ST_DONE : ssfm_pkg::ST_PROP_WAIT;
         end
         ssfm_pkg::ST_PROP_WAIT: begin
            if (status.div_done) state_in = ssfm_pkg::ST_DONE;
         end
         ssfm_pkg::ST_DONE: begin
            if (status.out_free) state_in = ssfm_pkg::ST_IDLE;
         end
         default: state_in = ssfm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.div_sel = ssfm_pkg::DIV_SLOW;
      req_tready = 1'b0;
      case (state_ff)
         ssfm_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
         ssfm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.latch  = req_tvalid;
         end
         ssfm_pkg::ST_REC_RD: cmd.mem_rd = 1'b1;
         ssfm_pkg::ST_REC_WR: cmd.rec_wr = 1'b1;
         ssfm_pkg::ST_Q_RD: begin
            cmd.walk_mode = 1'b1;
            cmd.mem_rd    = 1'b1;
         end
         ssfm_pkg::ST_Q_CHK: begin
            cmd.walk_mode = 1'b1;
            cmd.div_start = !status.alone_zero;
            cmd.walk_next = status.alone_zero && !status.walk_last;
         end
         ssfm_pkg::ST_Q_DIV: begin
            cmd.walk_mode = 1'b1;
            cmd.walk_upd  = status.div_done;
            cmd.walk_next = status.div_done && !status.walk_last;
         end
         ssfm_pkg::ST_FAIR: begin
            cmd.div_sel   = ssfm_pkg::DIV_FAIR;
            cmd.div_start = !status.fair_direct;
            cmd.fair_ld   = status.fair_direct;
         end
         ssfm_pkg::ST_FAIR_WAIT: cmd.fair_ld = status.div_done;
         ssfm_pkg::ST_PROP: begin
            cmd.div_sel   = ssfm_pkg::DIV_PROP;
            cmd.div_start = !status.prop_direct;
            cmd.prop_ld   = status.prop_direct;
         end
         ssfm_pkg::ST_PROP_WAIT: cmd.prop_ld = status.div_done;
         ssfm_pkg::ST_DONE: cmd.out_ld = status.out_free;
         default: cmd.latch = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/ssfm_dp.sv
// Datapath: request registers, stream sums, per-chip sum memory, counters,
// min/max walk, ratio logic and result register. Depends on ssfm_pkg, ssfm_div.
`default_nettype none

module ssfm_dp #(
   parameter int NUM_STREAMS       = ssfm_pkg::DEF_NUM_STREAMS,
   parameter int NUM_CHANNELS      = ssfm_pkg::DEF_NUM_CHANNELS,
   parameter int CHIPS_PER_CHANNEL = ssfm_pkg::DEF_CHIPS_PER_CHANNEL
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [ssfm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [0:0]                       req_tuser,
   input  wire logic                             rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [ssfm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire ssfm_pkg::cmd_type                cmd,
   output ssfm_pkg::status_type                  status
);

   localparam int SUM_W   = ssfm_pkg::SUM_W;
   localparam int CNT_W   = ssfm_pkg::CNT_W;
   localparam int SLOW_W  = ssfm_pkg::SLOW_W;
   localparam int FRAC_W  = ssfm_pkg::FRAC_W;
   localparam int DVD_W   = ssfm_pkg::DVD_W;
   localparam int ENTRIES = NUM_CHANNELS * CHIPS_PER_CHANNEL * NUM_STREAMS;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW      = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   // request fields
   logic                           type_ff;
   logic                           scope_ff;
   logic                           host_ff;
   logic [ssfm_pkg::STREAM_W-1:0]  stream_ff;
   logic [ssfm_pkg::CHAN_W-1:0]    chan_ff;
   logic [ssfm_pkg::CHIP_W-1:0]    chip_ff;
   logic [ssfm_pkg::KIND_W-1:0]    kind_ff;
   logic                           gc_ff;
   logic [ssfm_pkg::ALONE_W-1:0]   alone_ff;
   logic [ssfm_pkg::TIME_W-1:0]    issue_ff;
   logic [ssfm_pkg::TIME_W-1:0]    now_ff;

   logic [SUM_W-1:0] s_alone_ff [NUM_STREAMS];
   logic [SUM_W-1:0] s_shared_ff[NUM_STREAMS];
   logic [CNT_W-1:0] rd_tot_ff, rd_gc_ff, wr_tot_ff, wr_gc_ff;

   logic [ssfm_pkg::ENTRY_W-1:0] mem [ENTRIES];
   logic [ssfm_pkg::ENTRY_W-1:0] mem_q_ff;
   logic [AW-1:0]                clear_idx_ff;

   logic [SW-1:0]     walk_idx_ff;
   logic              any_ff, own_ok_ff;
   logic [SLOW_W-1:0] min_ff, max_ff, own_ff;

   logic [ssfm_pkg::FAIR_W-1:0] fair_ff;
   logic [ssfm_pkg::PROP_W-1:0] prop_ff;
   logic                        sat_ff;

   logic                        rsp_valid_ff;
   logic [ssfm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                 chip_ok, stream_ok, rec_en;
   logic [SW-1:0]        sidx;
   logic [AW-1:0]        rec_addr, walk_addr, rd_addr;
   logic [SUM_W-1:0]     shared_delta;
   logic [SUM_W-1:0]     sel_alone, sel_shared;
   logic [SUM_W-1:0]     new_s_alone, new_s_shared;
   logic [DVD_W-1:0]     dvd;
   logic [SLOW_W-1:0]    den;
   logic                 div_done;
   logic [DVD_W-1:0]     quo;
   logic [SLOW_W-1:0]    q_slow;
   logic                 own_hit;
   logic                 quo_sat;

   ssfm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (den),
      .done     (div_done),
      .quotient (quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff   <= req_tuser[0];
         scope_ff  <= req_tdata[0];
         host_ff   <= req_tdata[1];
         stream_ff <= req_tdata[3:2];
         chan_ff   <= req_tdata[6:4];
         chip_ff   <= req_tdata[8:7];
         kind_ff   <= req_tdata[10:9];
         gc_ff     <= req_tdata[11];
         alone_ff  <= req_tdata[43:12];
         issue_ff  <= req_tdata[91:44];
         now_ff    <= req_tdata[139:92];
      end
   end

   always_comb begin
      chip_ok   = (32'(chan_ff) < NUM_CHANNELS) && (32'(chip_ff) < CHIPS_PER_CHANNEL);
      stream_ok = 32'(stream_ff) < NUM_STREAMS;
      rec_en    = host_ff && stream_ok;
      sidx      = cmd.walk_mode ? walk_idx_ff : SW'(stream_ff);
      rec_addr  = AW'((32'(chan_ff) * CHIPS_PER_CHANNEL + 32'(chip_ff)) * NUM_STREAMS
                      + 32'(stream_ff));
      walk_addr = AW'((32'(chan_ff) * CHIPS_PER_CHANNEL + 32'(chip_ff)) * NUM_STREAMS
                      + 32'(walk_idx_ff));
      rd_addr   = cmd.walk_mode ? walk_addr : rec_addr;
      shared_delta = (now_ff >= issue_ff) ? now_ff - issue_ff : '0;
      new_s_alone  = ssfm_pkg::sat_add48(s_alone_ff[sidx], SUM_W'(alone_ff));
      new_s_shared = ssfm_pkg::sat_add48(s_shared_ff[sidx], shared_delta);
      if (scope_ff == ssfm_pkg::SCOPE_CHIP) begin
         sel_alone  = chip_ok ? mem_q_ff[2*SUM_W-1:SUM_W] : '0;
         sel_shared = chip_ok ? mem_q_ff[SUM_W-1:0] : '0;
      end else begin
         sel_alone  = s_alone_ff[sidx];
         sel_shared = s_shared_ff[sidx];
      end
   end

   // per-chip sum memory with clearing sweep after reset
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clear_idx_ff] <= '0;
      end else if (cmd.rec_wr && rec_en && chip_ok) begin
         mem[rec_addr] <= {ssfm_pkg::sat_add48(mem_q_ff[2*SUM_W-1:SUM_W], SUM_W'(alone_ff)),
                           ssfm_pkg::sat_add48(mem_q_ff[SUM_W-1:0], shared_delta)};
      end
      if (cmd.mem_rd) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STREAMS; i++) begin
            s_alone_ff[i]  <= '0;
            s_shared_ff[i] <= '0;
         end
         rd_tot_ff <= '0;
         rd_gc_ff  <= '0;
         wr_tot_ff <= '0;
         wr_gc_ff  <= '0;
      end else if (cmd.rec_wr && rec_en) begin
         for (int i = 0; i < NUM_STREAMS; i++) begin
            if (SW'(i) == sidx) begin
               s_alone_ff[i]  <= new_s_alone;
               s_shared_ff[i] <= new_s_shared;
            end
         end
         if (kind_ff == ssfm_pkg::KIND_READ) begin
            rd_tot_ff <= ssfm_pkg::sat_inc32(rd_tot_ff);
            if (gc_ff) rd_gc_ff <= ssfm_pkg::sat_inc32(rd_gc_ff);
         end else if (kind_ff == ssfm_pkg::KIND_WRITE) begin
            wr_tot_ff <= ssfm_pkg::sat_inc32(wr_tot_ff);
            if (gc_ff) wr_gc_ff <= ssfm_pkg::sat_inc32(wr_gc_ff);
         end
      end
   end

   // divider operands
   always_comb begin
      case (cmd.div_sel)
         ssfm_pkg::DIV_SLOW: begin
            dvd = {{(DVD_W - SUM_W - FRAC_W){1'b0}}, sel_shared, {FRAC_W{1'b0}}};
            den = SLOW_W'(sel_alone);
         end
         ssfm_pkg::DIV_FAIR: begin
            dvd = {min_ff, {FRAC_W{1'b0}}};
            den = max_ff;
         end
         ssfm_pkg::DIV_PROP: begin
            dvd = {min_ff, {FRAC_W{1'b0}}};
            den = own_ff;
         end
         default: begin
            dvd = '0;
            den = '0;
         end
      endcase
      q_slow  = quo[SLOW_W-1:0];
      own_hit = 32'(walk_idx_ff) == 32'(stream_ff);
      quo_sat = |quo[DVD_W-1:ssfm_pkg::PROP_W];
   end

   // stream walk: min, max and queried slowdown
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         walk_idx_ff <= '0;
         any_ff      <= 1'b0;
         own_ok_ff   <= 1'b0;
         fair_ff     <= '0;
         prop_ff     <= '0;
         sat_ff      <= 1'b0;
      end else begin
         if (cmd.walk_next) walk_idx_ff <= walk_idx_ff + 1'b1;
         if (cmd.walk_upd) begin
            if (!any_ff || q_slow < min_ff) min_ff <= q_slow;
            if (!any_ff || q_slow > max_ff) max_ff <= q_slow;
            any_ff <= 1'b1;
            if (own_hit) begin
               own_ff    <= q_slow;
               own_ok_ff <= 1'b1;
            end
         end
         if (cmd.fair_ld) begin
            if (!any_ff || max_ff == '0) fair_ff <= ssfm_pkg::FAIR_ONE;
            else if (min_ff == '0) fair_ff <= '0;
            else fair_ff <= quo[ssfm_pkg::FAIR_W-1:0];
         end
         if (cmd.prop_ld) begin
            if (!any_ff) begin
               prop_ff <= '1;
               sat_ff  <= 1'b1;
            end else if (!own_ok_ff) begin
               prop_ff <= '0;
               sat_ff  <= 1'b1;
            end else if (min_ff == '0) begin
               prop_ff <= '0;
               sat_ff  <= 1'b0;
            end else begin
               prop_ff <= quo_sat ? '1 : quo[ssfm_pkg::PROP_W-1:0];
               sat_ff  <= quo_sat;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_data_ff <= {6'b0, wr_gc_ff, wr_tot_ff, rd_gc_ff, rd_tot_ff,
                         sat_ff, prop_ff, fair_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.clear_last  = clear_idx_ff == AW'(ENTRIES - 1);
      status.is_query    = type_ff == ssfm_pkg::REQ_QUERY;
      status.alone_zero  = sel_alone == '0;
      status.walk_last   = walk_idx_ff == SW'(NUM_STREAMS - 1);
      status.div_done    = div_done;
      status.fair_direct = !any_ff || max_ff == '0 || min_ff == '0;
      status.prop_direct = !any_ff || !own_ok_ff || min_ff == '0;
      status.out_free    = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

### rtl/stream_slowdown_fairness_monitor.sv
// Top level of the stream slowdown and fairness monitor.
// Depends on ssfm_pkg, ssfm_ctrl, ssfm_dp (and ssfm_div below it).
//
// Accumulates per-stream and per-chip alone and shared time of completed host
// flash transactions plus read/write and GC-conflict counters, and answers
// fairness queries: fairness in Q1.16, proportional slowdown in Q16.16. One
// request is worked at a time; each request gives exactly one response, and
// the next request is taken while a response still waits. A host record
// updates the sums and counters; a query reads each stream's sums in turn,
// divides those with nonzero alone time, then divides for the fairness and
// proportional ratios where needed, all on the single shared divider, which
// retires one quotient bit per cycle over 80 bits. After reset a clearing
// pass over the NUM_CHANNELS * CHIPS_PER_CHANNEL * NUM_STREAMS entries
// (128 by default) zeroes the chip sum memory ahead of the first request.
`default_nettype none

module stream_slowdown_fairness_monitor #(
   parameter int NUM_STREAMS       = ssfm_pkg::DEF_NUM_STREAMS,
   parameter int NUM_CHANNELS      = ssfm_pkg::DEF_NUM_CHANNELS,
   parameter int CHIPS_PER_CHANNEL = ssfm_pkg::DEF_CHIPS_PER_CHANNEL
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // query_scope, source_is_host, stream_index, channel_index, chip_index,
   // access_kind, gc_conflict, alone_delta, issue_stamp, now_time, zero pad
   input  wire logic [ssfm_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type
   input  wire logic [0:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // fairness_q16, prop_slowdown_q16, ratio_saturated, serviced_reads,
   // read_gc_conflicts, serviced_writes, write_gc_conflicts, zero pad
   output logic [ssfm_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   ssfm_pkg::cmd_type    cmd;
   ssfm_pkg::status_type status;

   ssfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ssfm_dp #(
      .NUM_STREAMS       (NUM_STREAMS),
      .NUM_CHANNELS      (NUM_CHANNELS),
      .CHIPS_PER_CHANNEL (CHIPS_PER_CHANNEL)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

### rtl/ssfm_checker.sv
// Port-level checks for the stream slowdown monitor, bound to the top level.
// Depends on stream_slowdown_fairness_monitor port layout.
`default_nettype none

module ssfm_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [183:0] rsp_tdata
);

   // one request in flight
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_fair_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:0] <= 17'h10000)
      else $error("fairness above one");

   a_conflicts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[113:82] <= rsp_tdata[81:50]
                  && rsp_tdata[177:146] <= rsp_tdata[145:114])
      else $error("conflict count above service count");

endmodule

bind stream_slowdown_fairness_monitor ssfm_checker u_ssfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/sv/stream_slowdown_fairness_monitor_tb.sv
// Self-checking testbench of the stream slowdown and fairness monitor.
// Depends on ssfm_pkg and stream_slowdown_fairness_monitor; directed and random
// records and queries are scored against a slowdown/fairness predictor held in a class.
`timescale 1ns / 1ps

module stream_slowdown_fairness_monitor_tb;

   typedef struct packed {
      logic              is_query;
      logic              scope;
      logic              host;
      logic [1:0]        stream;
      logic [2:0]        chan;
      logic [1:0]        chip;
      logic [1:0]        kind;
      logic              gc;
      logic [31:0]       alone;
      logic [47:0]       issue;
      logic [47:0]       now;
   } request_type;

   typedef struct packed {
      logic [16:0] fair;
      logic [31:0] prop;
      logic        sat;
      logic [31:0] reads;
      logic [31:0] read_gc;
      logic [31:0] writes;
      logic [31:0] write_gc;
   } response_type;

   class slowdown_scoreboard;
      logic [47:0]  s_alone[4];
      logic [47:0]  s_shared[4];
      logic [47:0]  c_alone[128];
      logic [47:0]  c_shared[128];
      logic [31:0]  n_rd, n_rd_gc, n_wr, n_wr_gc;
      response_type expected_rsp[$];
      int           errors;

      function new();
         foreach (s_alone[i]) begin
            s_alone[i] = 0;
            s_shared[i] = 0;
         end
         foreach (c_alone[i]) begin
            c_alone[i] = 0;
            c_shared[i] = 0;
         end
         n_rd = 0; n_rd_gc = 0; n_wr = 0; n_wr_gc = 0;
         errors = 0;
      endfunction

      function logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
         logic [48:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[48] ? '1 : s[47:0];
      endfunction

      function logic [31:0] inc_sat(logic [31:0] a);
         return (a == '1) ? a : a + 32'd1;
      endfunction

      function logic [31:0] ratio_q16(logic [63:0] num, logic [63:0] den, inout logic sat);
         logic [63:0] ip;
         logic [79:0] rem;
         logic [79:0] frac;
         if (num == 0) return 0;
         if (den == 0) begin
            sat = 1;
            return '1;
         end
         ip = num / den;
         if (ip > 64'hFFFF) begin
            sat = 1;
            return '1;
         end
         rem = {16'd0, num % den} << 16;
         frac = rem / {16'd0, den};
         return {ip[15:0], frac[15:0]};
      endfunction

      function void note_request(request_type r);
         response_type e;
         logic [47:0]  shared, a, sh;
         logic [6:0]   k;
         logic [63:0]  q, min_q, max_q, own_q;
         logic         any, own_ok, sat;
         e = '0;
         k = {r.chan, r.chip, 2'b00};
         if (!r.is_query) begin
            if (r.host) begin
               shared = (r.now >= r.issue) ? r.now - r.issue : 48'd0;
               s_alone[r.stream] = add_sat(s_alone[r.stream], {16'd0, r.alone});
               s_shared[r.stream] = add_sat(s_shared[r.stream], shared);
               c_alone[k + r.stream] = add_sat(c_alone[k + r.stream], {16'd0, r.alone});
               c_shared[k + r.stream] = add_sat(c_shared[k + r.stream], shared);
               if (r.kind == ssfm_pkg::KIND_READ) begin
                  n_rd = inc_sat(n_rd);
                  if (r.gc) n_rd_gc = inc_sat(n_rd_gc);
               end else if (r.kind == ssfm_pkg::KIND_WRITE) begin
                  n_wr = inc_sat(n_wr);
                  if (r.gc) n_wr_gc = inc_sat(n_wr_gc);
               end
            end
         end else begin
            any = 0; own_ok = 0; sat = 0;
            min_q = 0; max_q = 0; own_q = 0;
            for (int s = 0; s < 4; s++) begin
               a = (r.scope == ssfm_pkg::SCOPE_CHIP) ? c_alone[k + s] : s_alone[s];
               sh = (r.scope == ssfm_pkg::SCOPE_CHIP) ? c_shared[k + s] : s_shared[s];
               if (a != 0) begin
                  q = {sh, 16'd0} / {16'd0, a};
                  if (!any || q < min_q) min_q = q;
                  if (!any || q > max_q) max_q = q;
                  any = 1;
                  if (s == int'(r.stream)) begin
                     own_ok = 1;
                     own_q = q;
                  end
               end
            end
            if (!any || max_q == 0) e.fair = ssfm_pkg::FAIR_ONE;
            else e.fair = 17'(ratio_q16(min_q, max_q, sat));
            sat = 0;
            if (!any) begin
               e.prop = '1;
               sat = 1;
            end else if (!own_ok) begin
               e.prop = 0;
               sat = 1;
            end else begin
               e.prop = ratio_q16(min_q, own_q, sat);
            end
            e.sat = sat;
         end
         e.reads = n_rd; e.read_gc = n_rd_gc; e.writes = n_wr; e.write_gc = n_wr_gc;
         expected_rsp.push_back(e);
      endfunction

      function void check_response(response_type act);
         response_type e;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response fair=%0d prop=%0h", act.fair, act.prop);
            return;
         end
         e = expected_rsp.pop_front();
         if (act != e) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp fair=%0d prop=%0h sat=%0d rd=%0d rdgc=%0d wr=%0d wrgc=%0d",
                        e.fair, e.prop, e.sat, e.reads, e.read_gc, e.writes, e.write_gc);
               $display("         got fair=%0d prop=%0h sat=%0d rd=%0d rdgc=%0d wr=%0d wrgc=%0d",
                        act.fair, act.prop, act.sat, act.reads, act.read_gc, act.writes,
                        act.write_gc);
            end
         end
      endfunction
   endclass

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_tvalid = 0;
   logic                            req_tready;
   logic [ssfm_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]                      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 0;
   logic [ssfm_pkg::RSP_DATA_W-1:0] rsp_tdata;

   slowdown_scoreboard sb = new();
   int  phase = 0;
   bit  hold_rsp = 0;
   int  quiet_cycles = 0;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_RANDOM = 450;

   stream_slowdown_fairness_monitor dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic logic [ssfm_pkg::REQ_DATA_W-1:0] pack_request(request_type r);
      return {4'd0, r.now, r.issue, r.alone, r.gc, r.kind, r.chip, r.chan, r.stream,
              r.host, r.scope};
   endfunction

   function automatic request_type make_request(bit q, bit sc, logic [1:0] st, logic [2:0] ch,
                                                logic [1:0] cp, logic [1:0] kd,
                                                logic [31:0] al, logic [47:0] is,
                                                logic [47:0] nw);
      request_type r;
      r.is_query = q; r.scope = sc; r.host = 1; r.stream = st; r.chan = ch; r.chip = cp;
      r.kind = kd; r.gc = 0; r.alone = al; r.issue = is; r.now = nw;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          p;
      logic [47:0] delta;
      r.is_query = ($urandom_range(0, 99) < 35);
      r.scope = 1'($urandom_range(0, 1));
      r.host = ($urandom_range(0, 9) != 0);
      r.stream = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) begin
         r.chan = 3'($urandom_range(0, 7));
         r.chip = 2'($urandom_range(0, 3));
      end else begin
         r.chan = 3'($urandom_range(0, 1));
         r.chip = 2'($urandom_range(0, 1));
      end
      r.kind = 2'($urandom_range(0, 3));
      r.gc = 1'($urandom_range(0, 1));
      p = $urandom_range(0, 99);
      if (p < 8) r.alone = 0;
      else if (p < 70) r.alone = $urandom_range(1, 1000);
      else if (p < 92) r.alone = $urandom;
      else r.alone = '1;
      r.issue = 48'({$urandom, $urandom});
      p = $urandom_range(0, 99);
      if (p < 60) delta = 48'($urandom_range(0, 5000));
      else if (p < 80) delta = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
      else delta = 0;
      if (p >= 90) begin
         r.now = r.issue - 48'($urandom_range(1, 1000));
      end else if (p >= 85) begin
         r.issue = 0;
         r.now = '1;
      end else begin
         r.now = r.issue + delta;
      end
      return r;
   endfunction

   task automatic send_request(request_type r, int idle_pct);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= pack_request(r);
      req_tuser <= r.is_query;
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         quiet_cycles <= 0;
      else if (!reset)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      response_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.fair = rsp_tdata[16:0];
         a.prop = rsp_tdata[48:17];
         a.sat = rsp_tdata[49];
         a.reads = rsp_tdata[81:50];
         a.read_gc = rsp_tdata[113:82];
         a.writes = rsp_tdata[145:114];
         a.write_gc = rsp_tdata[177:146];
         sb.check_response(a);
      end
   end

   always @(negedge clock) begin
      if (hold_rsp) rsp_tready <= 0;
      else if (phase == 2) rsp_tready <= ($urandom_range(0, 99) >= 75);
      else if (phase == 3) rsp_tready <= ($urandom_range(0, 99) >= 29);
      else rsp_tready <= 1;
   end

   initial begin
      request_type r;
      int          sender_idle;
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed part
      send_request(make_request(1, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_request(make_request(1, 1, 3, 7, 3, 0, 0, 0, 0), 0);
      send_request(make_request(0, 0, 0, 0, 0, 0, 100, 1000, 1300), 0);
      send_request(make_request(1, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      send_request(make_request(1, 0, 2, 0, 0, 0, 0, 0, 0), 0);
      r = make_request(0, 0, 1, 0, 0, 1, 50, 10, 20);
      r.gc = 1;
      send_request(r, 0);
      r = make_request(0, 0, 2, 0, 0, 0, 10, 500, 100);
      r.gc = 1;
      send_request(r, 0);
      send_request(make_request(0, 0, 3, 7, 3, 2, '1, 0, '1), 0);
      send_request(make_request(0, 0, 3, 7, 3, 3, 0, 0, '1), 0);
      r = make_request(0, 0, 0, 0, 0, 0, 999, 0, '1);
      r.host = 0;
      send_request(r, 0);
      send_request(make_request(1, 0, 1, 0, 0, 0, 0, 0, 0), 0);
      send_request(make_request(1, 0, 2, 0, 0, 0, 0, 0, 0), 0);
      send_request(make_request(1, 1, 3, 7, 3, 0, 0, 0, 0), 0);
      send_request(make_request(1, 1, 1, 7, 3, 0, 0, 0, 0), 0);
      send_request(make_request(0, 0, 1, 0, 0, 1, 0, 5, 5), 0);
      send_request(make_request(1, 1, 0, 0, 0, 0, 0, 0, 0), 0);
      send_request(make_request(1, 1, 2, 0, 0, 0, 0, 0, 0), 0);
      send_request(make_request(0, 0, 1, 0, 0, 0, 0, 0, '1), 0);
      send_request(make_request(0, 0, 1, 0, 0, 0, 0, 0, '1), 0);
      send_request(make_request(1, 0, 1, 0, 0, 0, 0, 0, 0), 0);
      // random part, phased idling
      for (int i = 0; i < NUM_RANDOM; i++) begin
         phase = i / (NUM_RANDOM / 4);
         if (i == 30) begin
            fork
               begin
                  hold_rsp = 1;
                  repeat (3000) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         sender_idle = (phase == 1) ? 75 : (phase == 3) ? 29 : 0;
         send_request(random_request(), sender_idle);
      end
      req_tvalid <= 0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
